[src/hca_pkg.sv]
`default_nettype none
package hca_pkg;

  localparam int unsigned DIV_QBITS          = 17;
  localparam int unsigned DIV_BITS_PER_STAGE = 4;
  localparam int unsigned DIV_STAGES         =
    (DIV_QBITS + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;

  localparam int unsigned MIDQ_DEPTH = 4;
  localparam int unsigned MIDQ_AW    = 2;
  localparam int unsigned OUTQ_DEPTH = 16;
  localparam int unsigned OUTQ_AW    = 4;

  localparam logic [16:0] DEG60    = 17'd15360;
  localparam logic [16:0] DEG360   = 17'd92160;
  localparam logic [21:0] RECIP15  = 22'd2236963;
  localparam int unsigned RECIP_SH = 25;

  typedef enum logic [1:0] {
    CFG_BRIGHTNESS = 2'd0,
    CFG_SATURATION = 2'd1,
    CFG_HUE        = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [2:0] emphasis_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_item_t;

  typedef struct packed {
    logic signed [16:0] bri;
    logic signed [18:0] sat;
    logic signed [14:0] hof256;
  } cfg_t;

  typedef struct packed {
    logic [24:0]        num_s;
    logic [7:0]         div_s;
    logic [24:0]        num_h;
    logic [7:0]         div_h;
    logic signed [17:0] v;
    logic               nz;
    logic [2:0]         code;
  } cls_t;

  typedef struct packed {
    logic [7:0]  rem;
    logic [16:0] quo;
  } dpart_t;

  typedef struct packed {
    dpart_t             ps;
    logic [16:0]        num_s;
    logic [7:0]         div_s;
    dpart_t             ph;
    logic [16:0]        num_h;
    logic [7:0]         div_h;
    logic signed [17:0] v;
    logic               nz;
    logic [2:0]         code;
  } divst_t;

  function automatic cfg_t cfg_derive(logic [7:0] bright, logic [7:0] satur,
                                      logic [7:0] hue_r);
    cfg_t               c;
    logic signed [8:0]  xb;
    logic signed [8:0]  xs;
    logic signed [8:0]  xh;
    logic [8:0]         hmag;
    logic [6:0]         hq;
    logic signed [6:0]  hof;
    xb = $signed({1'b0, bright}) - 9'sd128;
    xs = $signed({1'b0, satur}) - 9'sd128;
    xh = $signed({1'b0, hue_r}) - 9'sd128;
    c.bri = 17'(xb) * 17'sd257 - ((xb == -9'sd128) ? 17'sd1 : 17'sd0);
    c.sat = 19'sd65536 + 19'(xs) * 19'sd514
          + ((xs >= 9'sd64) ? 19'sd1 : ((xs <= -9'sd64) ? -19'sd1 : 19'sd0));
    hmag = xh[8] ? 9'(-xh) : 9'(xh);
    hq   = 7'(hmag >> 2);
    hof  = xh[8] ? -$signed(hq) : $signed(hq);
    c.hof256 = {hof, 8'd0};
    return c;
  endfunction

  // restoring division, a few quotient bits per pipeline stage
  function automatic dpart_t div_bits(dpart_t cur, logic [16:0] num, logic [7:0] d,
                                      int unsigned stage);
    dpart_t     res;
    logic [8:0] trial;
    int         bit_pos;
    res = cur;
    for (int j = 0; j < int'(DIV_BITS_PER_STAGE); j++) begin
      bit_pos = int'(DIV_QBITS) - 1 - int'(stage * DIV_BITS_PER_STAGE) - j;
      if (bit_pos >= 0) begin
        trial = {res.rem, num[bit_pos[4:0]]};
        if (trial >= {1'b0, d}) begin
          res.rem = 8'(trial - {1'b0, d});
          res.quo[bit_pos[4:0]] = 1'b1;
        end else begin
          res.rem = trial[7:0];
        end
      end
    end
    return res;
  endfunction

  function automatic logic [26:0] emph_row(logic [2:0] code);
    logic [26:0] row;
    unique case (code)
      3'd0: row = {9'd256, 9'd256, 9'd256};
      3'd1: row = {9'd256, 9'd205, 9'd207};
      3'd2: row = {9'd200, 9'd241, 9'd169};
      3'd3: row = {9'd202, 9'd197, 9'd161};
      3'd4: row = {9'd210, 9'd212, 9'd287};
      3'd5: row = {9'd207, 9'd182, 9'd223};
      3'd6: row = {9'd174, 9'd202, 9'd202};
      3'd7: row = {9'd179, 9'd179, 9'd179};
    endcase
    return row;
  endfunction

endpackage
`default_nettype wire

[src/hca_front.sv]
`default_nettype none
module hca_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire hca_pkg::in_item_t item_i,
  input  wire hca_pkg::cfg_t     cfg_i,
  input  wire logic              deq_i,
  output logic                   avail_o,
  output hca_pkg::cls_t          head_o
);
  import hca_pkg::*;

  logic [7:0]         r, g, b, mx, mn, delta;
  logic signed [11:0] gs, bs, rs, dl, num_sig;
  logic [10:0]        num_u;
  logic [16:0]        vm;
  cls_t               cls;
  logic               wr_en;

  cls_t               mem_q [MIDQ_DEPTH];
  logic [MIDQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [MIDQ_AW:0]   cnt_q, cnt_d;

  always_comb begin
    r = item_i.src_red;
    g = item_i.src_green;
    b = item_i.src_blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    rs = $signed({4'd0, r});
    gs = $signed({4'd0, g});
    bs = $signed({4'd0, b});
    dl = $signed({4'd0, delta});
    if (r == mx) begin
      num_sig = ((g >= b) ? 12'sd0 : 12'sd6 * dl) + (gs - bs);
    end else if (g == mx) begin
      num_sig = 12'sd2 * dl + (bs - rs);
    end else begin
      num_sig = 12'sd4 * dl + (rs - gs);
    end
    num_u = 11'(num_sig);
    vm = 17'(mx) * 17'd257 + (mx[7] ? 17'd1 : 17'd0);
    cls.num_s = 25'({delta, 16'd0}) + 25'(mx >> 1);
    cls.div_s = (mx == 8'd0) ? 8'd1 : mx;
    cls.num_h = 25'(num_u) * 25'd15360 + 25'(delta >> 1);
    cls.div_h = (delta == 8'd0) ? 8'd1 : delta;
    cls.v     = $signed({1'b0, vm}) + 18'(cfg_i.bri);
    cls.nz    = (delta != 8'd0);
    cls.code  = item_i.emphasis_code;
  end

  assign full    = (cnt_q == (MIDQ_AW+1)'(MIDQ_DEPTH));
  assign avail_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign wr_en   = push && !full;

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !deq_i) cnt_d = cnt_q + 1'b1;
    if (!wr_en && deq_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (deq_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_ptr_q] <= cls;
  end

endmodule
`default_nettype wire

[src/hca_back.sv]
`default_nettype none
module hca_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            avail_i,
  input  wire hca_pkg::cls_t   head_i,
  input  wire hca_pkg::cfg_t   cfg_i,
  input  wire logic [hca_pkg::OUTQ_AW:0] outq_cnt_i,
  output logic                 deq_o,
  output logic                 res_valid_o,
  output hca_pkg::out_item_t   res_o
);
  import hca_pkg::*;

  function automatic logic signed [23:0] rnd16(logic signed [39:0] n);
    logic [39:0] mag;
    logic [23:0] q;
    mag = n[39] ? 40'(-n) : 40'(n);
    q   = 24'((mag + 40'd32768) >> 16);
    return n[39] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [7:0] to_byte(logic signed [29:0] ce);
    logic [39:0] x;
    logic [39:0] rr;
    logic [7:0]  res;
    x  = ({11'd0, ce[28:0]} << 8) - {11'd0, ce[28:0]};
    rr = (x + 40'd8388608) >> 24;
    if (ce[29])               res = 8'd0;
    else if (rr > 40'd255)    res = 8'd255;
    else                      res = rr[7:0];
    return res;
  endfunction

  logic                  issue;
  logic [OUTQ_AW:0]      inflight_q, inflight_d;
  logic [OUTQ_AW+1:0]    used;

  divst_t                dv_q [DIV_STAGES];
  divst_t                dv_d [DIV_STAGES];
  logic [DIV_STAGES-1:0] dv_vld_q;
  divst_t                dv_init;
  divst_t                dl;

  logic                  e1_vld_q, e2_vld_q, e3_vld_q, e4_vld_q, e5_vld_q;
  logic                  e6_vld_q, e7_vld_q, e8_vld_q, e9_vld_q;

  logic signed [36:0]    e1_sprod_q;
  logic [16:0]           e1_h_q;
  logic signed [17:0]    e1_v_q;
  logic                  e1_nz_q;
  logic [2:0]            e1_code_q;
  logic signed [18:0]    hw;

  logic signed [18:0]    e2_s_q;
  logic [2:0]            e2_sec_q;
  logic [13:0]           e2_f_q;
  logic signed [17:0]    e2_v_q;
  logic [2:0]            e2_code_q;
  logic [2:0]            sec;
  logic [16:0]           sec_off;

  logic signed [33:0]    e3_sfp_q;
  logic signed [18:0]    e3_s_q;
  logic [2:0]            e3_sec_q;
  logic signed [17:0]    e3_v_q;
  logic [2:0]            e3_code_q;

  logic [33:0]           sf_mag;
  logic [20:0]           sf_m;
  logic [42:0]           e4_x_q;
  logic                  e4_neg_q;
  logic signed [18:0]    e4_s_q;
  logic [2:0]            e4_sec_q;
  logic signed [17:0]    e4_v_q;
  logic [2:0]            e4_code_q;

  logic [17:0]           sf_quo;
  logic signed [18:0]    e5_sf_q;
  logic signed [18:0]    e5_s_q;
  logic [2:0]            e5_sec_q;
  logic signed [17:0]    e5_v_q;
  logic [2:0]            e5_code_q;

  logic signed [19:0]    op_p, op_q, op_t;
  logic signed [37:0]    e6_pp_q, e6_pq_q, e6_pt_q;
  logic                  e6_gray_q;
  logic [2:0]            e6_sec_q;
  logic signed [17:0]    e6_v_q;
  logic [2:0]            e6_code_q;

  logic signed [19:0]    cp, cq, ct, cv;
  logic signed [19:0]    ch_r, ch_g, ch_b;
  logic signed [19:0]    e7_r_q, e7_g_q, e7_b_q;
  logic [2:0]            e7_code_q;

  logic [26:0]           erow;
  logic signed [29:0]    e8_r_q, e8_g_q, e8_b_q;

  assign used  = (OUTQ_AW+2)'(inflight_q) + (OUTQ_AW+2)'(outq_cnt_i);
  assign issue = avail_i && (used < (OUTQ_AW+2)'(OUTQ_DEPTH));
  assign deq_o = issue;

  always_comb begin
    inflight_d = inflight_q;
    if (issue && !e9_vld_q) inflight_d = inflight_q + 1'b1;
    if (!issue && e9_vld_q) inflight_d = inflight_q - 1'b1;
  end

  // divider stages: saturation ratio and hue quotient in parallel
  always_comb begin
    dv_init.ps.rem = head_i.num_s[24:17];
    dv_init.ps.quo = '0;
    dv_init.num_s  = head_i.num_s[16:0];
    dv_init.div_s  = head_i.div_s;
    dv_init.ph.rem = head_i.num_h[24:17];
    dv_init.ph.quo = '0;
    dv_init.num_h  = head_i.num_h[16:0];
    dv_init.div_h  = head_i.div_h;
    dv_init.v      = head_i.v;
    dv_init.nz     = head_i.nz;
    dv_init.code   = head_i.code;
    for (int unsigned k = 0; k < DIV_STAGES; k++) begin
      dv_d[k]    = (k == 0) ? dv_init : dv_q[k-1];
      dv_d[k].ps = div_bits(dv_d[k].ps, dv_d[k].num_s, dv_d[k].div_s, k);
      dv_d[k].ph = div_bits(dv_d[k].ph, dv_d[k].num_h, dv_d[k].div_h, k);
    end
  end

  assign dl = dv_q[DIV_STAGES-1];

  always_comb begin
    hw = $signed({2'b00, dl.ph.quo}) - 19'(cfg_i.hof256);
    if (hw >= $signed({2'b00, DEG360})) hw = hw - $signed({2'b00, DEG360});
    else if (hw < 19'sd0)             hw = hw + $signed({2'b00, DEG360});
  end

  always_comb begin
    priority if (e1_h_q >= 17'(5 * DEG60)) begin
      sec = 3'd5; sec_off = 17'(5 * DEG60);
    end else if (e1_h_q >= 17'(4 * DEG60)) begin
      sec = 3'd4; sec_off = 17'(4 * DEG60);
    end else if (e1_h_q >= 17'(3 * DEG60)) begin
      sec = 3'd3; sec_off = 17'(3 * DEG60);
    end else if (e1_h_q >= 17'(2 * DEG60)) begin
      sec = 3'd2; sec_off = 17'(2 * DEG60);
    end else if (e1_h_q >= DEG60) begin
      sec = 3'd1; sec_off = DEG60;
    end else begin
      sec = 3'd0; sec_off = '0;
    end
  end

  always_comb begin
    sf_mag = e3_sfp_q[33] ? 34'(-e3_sfp_q) : 34'(e3_sfp_q);
    sf_m   = 21'((sf_mag + 34'd7680) >> 10);
    sf_quo = 18'(e4_x_q >> RECIP_SH);
    op_p   = 20'sd65536 - 20'(e5_s_q);
    op_q   = 20'sd65536 - 20'(e5_sf_q);
    op_t   = 20'sd65536 - (20'(e5_s_q) - 20'(e5_sf_q));
  end

  always_comb begin
    cp = 20'(rnd16(40'(e6_pp_q)));
    cq = 20'(rnd16(40'(e6_pq_q)));
    ct = 20'(rnd16(40'(e6_pt_q)));
    cv = 20'(e6_v_q);
    if (e6_gray_q) begin
      ch_r = cv; ch_g = cv; ch_b = cv;
    end else begin
      unique case (e6_sec_q)
        3'd0:    begin ch_r = cv; ch_g = ct; ch_b = cp; end
        3'd1:    begin ch_r = cq; ch_g = cv; ch_b = cp; end
        3'd2:    begin ch_r = cp; ch_g = cv; ch_b = ct; end
        3'd3:    begin ch_r = cp; ch_g = cq; ch_b = cv; end
        3'd4:    begin ch_r = ct; ch_g = cp; ch_b = cv; end
        default: begin ch_r = cv; ch_g = cp; ch_b = cq; end
      endcase
    end
  end

  assign erow = emph_row(e7_code_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
      dv_vld_q   <= '0;
      e1_vld_q   <= 1'b0;
      e2_vld_q   <= 1'b0;
      e3_vld_q   <= 1'b0;
      e4_vld_q   <= 1'b0;
      e5_vld_q   <= 1'b0;
      e6_vld_q   <= 1'b0;
      e7_vld_q   <= 1'b0;
      e8_vld_q   <= 1'b0;
      e9_vld_q   <= 1'b0;
    end else begin
      inflight_q <= inflight_d;
      dv_vld_q   <= {dv_vld_q[DIV_STAGES-2:0], issue};
      e1_vld_q   <= dv_vld_q[DIV_STAGES-1];
      e2_vld_q   <= e1_vld_q;
      e3_vld_q   <= e2_vld_q;
      e4_vld_q   <= e3_vld_q;
      e5_vld_q   <= e4_vld_q;
      e6_vld_q   <= e5_vld_q;
      e7_vld_q   <= e6_vld_q;
      e8_vld_q   <= e7_vld_q;
      e9_vld_q   <= e8_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int unsigned k = 0; k < DIV_STAGES; k++) begin
      dv_q[k] <= dv_d[k];
    end

    e1_sprod_q <= $signed({1'b0, dl.ps.quo}) * cfg_i.sat;
    e1_h_q     <= 17'(hw);
    e1_v_q     <= dl.v;
    e1_nz_q    <= dl.nz;
    e1_code_q  <= dl.code;

    e2_s_q    <= e1_nz_q ? 19'(rnd16(40'(e1_sprod_q))) : 19'sd0;
    e2_sec_q  <= sec;
    e2_f_q    <= 14'(e1_h_q - sec_off);
    e2_v_q    <= e1_v_q;
    e2_code_q <= e1_code_q;

    e3_sfp_q  <= e2_s_q * $signed({1'b0, e2_f_q});
    e3_s_q    <= e2_s_q;
    e3_sec_q  <= e2_sec_q;
    e3_v_q    <= e2_v_q;
    e3_code_q <= e2_code_q;

    e4_x_q    <= 43'(sf_m) * 43'(RECIP15);
    e4_neg_q  <= e3_sfp_q[33];
    e4_s_q    <= e3_s_q;
    e4_sec_q  <= e3_sec_q;
    e4_v_q    <= e3_v_q;
    e4_code_q <= e3_code_q;

    e5_sf_q   <= e4_neg_q ? -$signed({1'b0, sf_quo}) : $signed({1'b0, sf_quo});
    e5_s_q    <= e4_s_q;
    e5_sec_q  <= e4_sec_q;
    e5_v_q    <= e4_v_q;
    e5_code_q <= e4_code_q;

    e6_pp_q   <= e5_v_q * op_p;
    e6_pq_q   <= e5_v_q * op_q;
    e6_pt_q   <= e5_v_q * op_t;
    e6_gray_q <= (e5_s_q == 19'sd0);
    e6_sec_q  <= e5_sec_q;
    e6_v_q    <= e5_v_q;
    e6_code_q <= e5_code_q;

    e7_r_q    <= ch_r;
    e7_g_q    <= ch_g;
    e7_b_q    <= ch_b;
    e7_code_q <= e6_code_q;

    e8_r_q <= e7_r_q * $signed({1'b0, erow[26:18]});
    e8_g_q <= e7_g_q * $signed({1'b0, erow[17:9]});
    e8_b_q <= e7_b_q * $signed({1'b0, erow[8:0]});

    res_o.out_red   <= to_byte(e8_r_q);
    res_o.out_green <= to_byte(e8_g_q);
    res_o.out_blue  <= to_byte(e8_b_q);
  end

  assign res_valid_o = e9_vld_q;

endmodule
`default_nettype wire

[src/hca_outq.sv]
`default_nettype none
module hca_outq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_i,
  input  wire hca_pkg::out_item_t item_i,
  input  wire logic               pop,
  output logic                    empty,
  output hca_pkg::out_item_t      item_o,
  output logic [hca_pkg::OUTQ_AW:0] cnt_o
);
  import hca_pkg::*;

  out_item_t          mem_q [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUTQ_AW:0]   cnt_q, cnt_d;
  logic               rd_en;

  assign empty  = (cnt_q == '0);
  assign rd_en  = pop && !empty;
  assign item_o = mem_q[rd_ptr_q];
  assign cnt_o  = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (wr_i && !rd_en) cnt_d = cnt_q + 1'b1;
    if (!wr_i && rd_en) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i)  wr_ptr_q <= wr_ptr_q + 1'b1;
      if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wr_ptr_q] <= item_i;
  end

endmodule
`default_nettype wire

[src/hsv_color_adjust_with_emphasis_unit.sv]
// Path: an accepted item goes through the input queue, 5 divider stages, 9 arithmetic stages
// and the result queue, from which it is popped.
// Throughput: one item per cycle while the 16-entry result queue gives the pipeline credit.
// Reset: queues empty, brightness, saturation and hue registers return to 128.
`default_nettype none
module hsv_color_adjust_with_emphasis_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire hca_pkg::in_item_t  in_item_i,
  output logic                    empty,
  input  wire logic               pop,
  output hca_pkg::out_item_t      result_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [7:0]         cfg_data_i
);
  import hca_pkg::*;

  logic [7:0]       bright_q, sat_q, hue_q;
  cfg_t             cfg;
  logic             deq, avail, res_valid;
  cls_t             head;
  out_item_t        res;
  logic [OUTQ_AW:0] outq_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= 8'd128;
      sat_q    <= 8'd128;
      hue_q    <= 8'd128;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BRIGHTNESS: bright_q <= cfg_data_i;
        CFG_SATURATION: sat_q    <= cfg_data_i;
        CFG_HUE:        hue_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_derive(bright_q, sat_q, hue_q);

  hca_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (in_item_i),
    .cfg_i   (cfg),
    .deq_i   (deq),
    .avail_o (avail),
    .head_o  (head)
  );

  hca_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (avail),
    .head_i      (head),
    .cfg_i       (cfg),
    .outq_cnt_i  (outq_cnt),
    .deq_o       (deq),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  hca_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (res_valid),
    .item_i (res),
    .pop    (pop),
    .empty  (empty),
    .item_o (result_o),
    .cnt_o  (outq_cnt)
  );

endmodule
`default_nettype wire

[verif/tb_top.sv]
`default_nettype none
module tb_top;
  import hca_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_item_i = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t result_o;
  logic      cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [7:0] cfg_data_i = '0;

  hsv_color_adjust_with_emphasis_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .in_item_i(in_item_i),
    .empty(empty), .pop(pop), .result_o(result_o), .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  typedef struct {
    in_item_t  px;
    bit        has_known;
    out_item_t known;
  } stim_row_t;

  logic [7:0] bright_r = 8'd128, satur_r = 8'd128, hue_r = 8'd128;
  out_item_t  expected_colors[$];
  int         errors = 0;
  int         cycles = 0;
  bit         hold_off = 1'b0;
  bit         stim_done = 1'b0;
  int         accepted = 0;

  function automatic longint rnd_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return rnd_div(a * b, 65536);
  endfunction

  function automatic logic [7:0] chan_byte(longint c, longint e);
    longint p;
    p = c * e * 255;
    if (p < 0) return 8'd0;
    p = (p + (longint'(1) << 23)) >>> 24;
    return (p > 255) ? 8'd255 : 8'(p);
  endfunction

  function automatic out_item_t adjust_color(in_item_t px);
    longint r, g, b, mx, mn, dl, v, s, h, bri, sat, hof, num, sec, f, sf, p, q, t;
    longint ch[3];
    logic [26:0] row;
    out_item_t o;
    r = px.src_red; g = px.src_green; b = px.src_blue;
    bri = rnd_div((longint'(bright_r) - 128) * 65536, 255);
    sat = 65536 + rnd_div((longint'(satur_r) - 128) * 2 * 65536, 255);
    hof = (longint'(hue_r) - 128) / 4;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dl = mx - mn;
    v = rnd_div(mx * 65536, 255) + bri;
    s = 0; h = 0;
    if (mx != 0 && dl != 0) begin
      s = qmul(rnd_div(dl * 65536, mx), sat);
      if (r == mx) num = ((g >= b) ? 0 : 6 * dl) + (g - b);
      else if (g == mx) num = 2 * dl + (b - r);
      else num = 4 * dl + (r - g);
      h = (num * 15360 + dl / 2) / dl;
      h -= hof * 256;
      if (h >= 92160) h -= 92160;
      else if (h < 0) h += 92160;
    end
    if (s == 0) begin
      ch[0] = v; ch[1] = v; ch[2] = v;
    end else begin
      sec = h / 15360;
      f = h - sec * 15360;
      sf = rnd_div(s * f, 15360);
      p = qmul(v, 65536 - s);
      q = qmul(v, 65536 - sf);
      t = qmul(v, 65536 - (s - sf));
      case (sec)
        0: begin ch[0] = v; ch[1] = t; ch[2] = p; end
        1: begin ch[0] = q; ch[1] = v; ch[2] = p; end
        2: begin ch[0] = p; ch[1] = v; ch[2] = t; end
        3: begin ch[0] = p; ch[1] = q; ch[2] = v; end
        4: begin ch[0] = t; ch[1] = p; ch[2] = v; end
        default: begin ch[0] = v; ch[1] = p; ch[2] = q; end
      endcase
    end
    case (px.emphasis_code)
      3'd0: row = {9'd256, 9'd256, 9'd256};
      3'd1: row = {9'd256, 9'd205, 9'd207};
      3'd2: row = {9'd200, 9'd241, 9'd169};
      3'd3: row = {9'd202, 9'd197, 9'd161};
      3'd4: row = {9'd210, 9'd212, 9'd287};
      3'd5: row = {9'd207, 9'd182, 9'd223};
      3'd6: row = {9'd174, 9'd202, 9'd202};
      default: row = {9'd179, 9'd179, 9'd179};
    endcase
    o.out_red   = chan_byte(ch[0], row[26:18]);
    o.out_green = chan_byte(ch[1], row[17:9]);
    o.out_blue  = chan_byte(ch[2], row[8:0]);
    return o;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BRIGHTNESS: bright_r = val;
      CFG_SATURATION: satur_r = val;
      default: hue_r = val;
    endcase
  endtask

  task automatic send_color(in_item_t px, bit has_known, out_item_t known, bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= px;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    expected_colors.push_back(has_known ? known : adjust_color(px));
    accepted++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_colors.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic in_item_t rand_color();
    in_item_t px;
    px.src_red = 8'($urandom);
    px.src_green = 8'($urandom);
    px.src_blue = 8'($urandom);
    case ($urandom_range(0, 9))
      0: px.src_green = px.src_red;
      1: begin px.src_green = px.src_red; px.src_blue = px.src_red; end
      2: px.src_blue = px.src_green;
      3: begin px.src_red = 8'd0; px.src_green = 8'd0; px.src_blue = 8'd0; end
      4: px.src_red = 8'd255;
      default: ;
    endcase
    px.emphasis_code = 3'($urandom);
    return px;
  endfunction

  // receiver
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        pop <= 1'b0;
      end else begin
        g = gap_len();
        if (g > 0) begin
          pop <= 1'b0;
          repeat (g - 1) @(negedge clk_i);
        end else begin
          pop <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_colors.size() == 0) begin
        $display("%0t: unexpected item %h", $time, result_o);
        errors++;
      end else begin
        out_item_t e;
        e = expected_colors.pop_front();
        if (result_o.out_red !== e.out_red)
          $display("%0t: out_red exp %0d got %0d", $time, e.out_red, result_o.out_red);
        if (result_o.out_green !== e.out_green)
          $display("%0t: out_green exp %0d got %0d", $time, e.out_green, result_o.out_green);
        if (result_o.out_blue !== e.out_blue)
          $display("%0t: out_blue exp %0d got %0d", $time, e.out_blue, result_o.out_blue);
        if (result_o !== e) errors++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("hsv_color_adjust_with_emphasis_unit test failed");
      $finish;
    end
  end

  // hold-off for pressure
  initial begin
    wait (accepted >= 300);
    hold_off = 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    stim_row_t rows[$];
    in_item_t px;
    logic [7:0] settings[6][3];
    rows.push_back('{'{8'd0, 8'd0, 8'd0, 3'd0}, 1'b1, '{8'd0, 8'd0, 8'd0}});
    rows.push_back('{'{8'd255, 8'd255, 8'd255, 3'd0}, 1'b1, '{8'd255, 8'd255, 8'd255}});
    rows.push_back('{'{8'd128, 8'd128, 8'd128, 3'd0}, 1'b1, '{8'd128, 8'd128, 8'd128}});
    rows.push_back('{'{8'd255, 8'd0, 8'd0, 3'd0}, 1'b1, '{8'd255, 8'd0, 8'd0}});
    rows.push_back('{'{8'd0, 8'd255, 8'd0, 3'd0}, 1'b1, '{8'd0, 8'd255, 8'd0}});
    rows.push_back('{'{8'd0, 8'd0, 8'd255, 3'd0}, 1'b1, '{8'd0, 8'd0, 8'd255}});
    rows.push_back('{'{8'd255, 8'd255, 8'd255, 3'd7}, 1'b1, '{8'd178, 8'd178, 8'd178}});
    for (int c = 1; c < 8; c++)
      rows.push_back('{'{8'd255, 8'd170, 8'd85, 3'(c)}, 1'b0, '{8'd0, 8'd0, 8'd0}});
    rows.push_back('{'{8'd255, 8'd0, 8'd255, 3'd4}, 1'b0, '{8'd0, 8'd0, 8'd0}});
    rows.push_back('{'{8'd10, 8'd200, 8'd30, 3'd2}, 1'b0, '{8'd0, 8'd0, 8'd0}});
    rows.push_back('{'{8'd1, 8'd0, 8'd0, 3'd1}, 1'b0, '{8'd0, 8'd0, 8'd0}});
    rows.push_back('{'{8'd100, 8'd100, 8'd99, 3'd5}, 1'b0, '{8'd0, 8'd0, 8'd0}});

    settings = '{'{8'd128, 8'd128, 8'd128}, '{8'd0, 8'd0, 8'd0},
                 '{8'd255, 8'd255, 8'd255}, '{8'd200, 8'd1, 8'd3},
                 '{8'd60, 8'd190, 8'd250}, '{8'd128, 8'd128, 8'd128}};

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_color(rows[i].px, rows[i].has_known, rows[i].known, 1'b0);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_BRIGHTNESS, settings[ph][0]);
      write_reg(CFG_SATURATION, settings[ph][1]);
      write_reg(CFG_HUE, settings[ph][2]);
      for (int n = 0; n < 155; n++) begin
        px = rand_color();
        send_color(px, 1'b0, '0, (n % 50) < 15);
      end
      drain();
    end
    stim_done = 1'b1;
    drain();
    if (errors == 0) begin
      $display("hsv_color_adjust_with_emphasis_unit test passed");
    end else begin
      $display("hsv_color_adjust_with_emphasis_unit test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
